[hw/rtl/snf_pkg.sv]
// Package: shared widths, command codes, register indexes and types of the serial NOR flash.
`timescale 1ns / 1ps
package snf_pkg;

	localparam int MODE_W  = 3;
	localparam int ADDR_W  = 16;
	localparam int LEN_W   = 9;
	localparam int DATA_W  = 8;
	localparam int VALUE_W = 32;
	localparam int CAP_W   = 17;
	localparam int PDATA_W = 32;
	localparam int PADDR_W = 3;

	localparam int MEM_BYTES_DEF    = 65536;
	localparam int PAGE_BYTES_DEF   = 256;
	localparam int MAX_READ_RUN_DEF = 64;

	localparam logic [MODE_W-1:0] MODE_READ   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_WREN   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ERASE  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_PROG   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_STATUS = 3'd4;
	localparam logic [MODE_W-1:0] MODE_ID     = 3'd5;

	localparam logic REG_DEVICE_ID = 1'b0;
	localparam logic REG_CAPACITY  = 1'b1;

	localparam logic [CAP_W-1:0]   CAP_RESET       = 17'd65536;
	localparam logic [DATA_W-1:0]  ERASED_BYTE     = 8'hFF;
	localparam logic [DATA_W-1:0]  CLEARED_BYTE    = 8'h00;
	localparam logic [VALUE_W-1:0] STATUS_WEL_MASK = 32'h0000_0002;

	typedef struct packed {
		logic [VALUE_W-1:0] device_id;
		logic [CAP_W-1:0]   capacity;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_READ  = 4'b0100,
		ST_ERASE = 4'b1000
	} state_t;

endpackage

[hw/rtl/snf_stream_if.sv]
// Interfaces: command and response channels with valid/ready handshake.
`timescale 1ns / 1ps
interface snf_cmd_if;
	import snf_pkg::*;

	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [ADDR_W-1:0] address;
	logic [LEN_W-1:0]  length;
	logic [DATA_W-1:0] data_byte;

	modport source (output valid, output mode, output address, output length,
		output data_byte, input ready);
	modport sink (input valid, input mode, input address, input length,
		input data_byte, output ready);
	modport monitor (input valid, input ready, input mode, input address, input length,
		input data_byte);
endinterface

interface snf_rsp_if;
	import snf_pkg::*;

	logic               valid;
	logic               ready;
	logic               ok;
	logic [VALUE_W-1:0] value;
	logic               last;

	modport source (output valid, output ok, output value, output last, input ready);
	modport sink (input valid, input ok, input value, input last, output ready);
	modport monitor (input valid, input ready, input ok, input value, input last);
endinterface

[hw/rtl/snf_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
module snf_ram #(
	parameter int WIDTH = snf_pkg::DATA_W,
	parameter int DEPTH = snf_pkg::MEM_BYTES_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[hw/rtl/snf_cfg.sv]
// APB-style configuration registers: device ID and capacity.
`timescale 1ns / 1ps
module snf_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [snf_pkg::PADDR_W-1:0] paddr,
	input  logic [snf_pkg::PDATA_W-1:0] pwdata,
	output logic [snf_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	output snf_pkg::cfg_t               cfg
);
	import snf_pkg::*;

	logic               wr;
	logic               idx;
	logic [VALUE_W-1:0] device_id_q;
	logic [CAP_W-1:0]   capacity_q;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;
	// registers sit on a 4-byte stride
	assign idx    = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_id_q <= '0;
			capacity_q  <= CAP_RESET;
		end else if (wr) begin
			unique case (idx)
				REG_DEVICE_ID: device_id_q <= pwdata;
				REG_CAPACITY:  capacity_q  <= pwdata[CAP_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_DEVICE_ID: prdata = device_id_q;
			REG_CAPACITY:  prdata = PDATA_W'(capacity_q);
		endcase
	end

	assign cfg.device_id = device_id_q;
	assign cfg.capacity  = capacity_q;
endmodule

[hw/rtl/snf_ctrl.sv]
// Command sequencer: checks, read runs, page erase walk, program writes, clearing pass.
`timescale 1ns / 1ps
module snf_ctrl #(
	parameter int MEM_BYTES    = snf_pkg::MEM_BYTES_DEF,
	parameter int PAGE_BYTES   = snf_pkg::PAGE_BYTES_DEF,
	parameter int MAX_READ_RUN = snf_pkg::MAX_READ_RUN_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  snf_pkg::cfg_t                cfg,
	snf_cmd_if.sink                      cmd,
	snf_rsp_if.source                    rsp,
	output logic                         mem_we,
	output logic [$clog2(MEM_BYTES)-1:0] mem_waddr,
	output logic [snf_pkg::DATA_W-1:0]   mem_wdata,
	output logic                         mem_re,
	output logic [$clog2(MEM_BYTES)-1:0] mem_raddr,
	input  logic [snf_pkg::DATA_W-1:0]   mem_rdata
);
	import snf_pkg::*;

	localparam int AW = $clog2(MEM_BYTES);
	localparam int XW = (AW + 1 > 18) ? AW + 1 : 18;
	localparam int PW = $clog2(PAGE_BYTES);
	localparam int RW = $clog2(MAX_READ_RUN + 1);

	state_t             st_q, st_d;
	logic               wel_q, wel_d;
	logic [LEN_W-1:0]   po_q, po_d;
	logic [AW-1:0]      clr_q, clr_d;
	logic [XW-1:0]      ea_q, ea_d;
	logic [XW-1:0]      ee_q, ee_d;
	logic [AW-1:0]      rd_ptr_q, rd_ptr_d;
	logic [RW-1:0]      rd_len_q, rd_len_d;
	logic [RW-1:0]      iss_q, iss_d;
	logic [RW-1:0]      mv_q, mv_d;
	logic               pend_q, pend_d;
	logic               out_v_q;
	logic               rsp_ok_q;
	logic [VALUE_W-1:0] rsp_val_q;
	logic               rsp_last_q;

	logic               out_free, acc;
	logic               ld, ld_ok, ld_last;
	logic [VALUE_W-1:0] ld_val;
	logic [XW-1:0]      cap_x, addr_x, len_x, end_x;
	logic [XW-1:0]      pg_base, pg_end_raw, pg_end, pr_addr;
	logic               rd_ok, er_ok, pr_ok, pr_fin;
	logic               move, issue, rd_last;

	// effective capacity, clamped to the store size
	assign cap_x  = (XW'(cfg.capacity) > XW'(MEM_BYTES)) ? XW'(MEM_BYTES) : XW'(cfg.capacity);
	assign addr_x = XW'(cmd.address);
	assign len_x  = XW'(cmd.length);
	assign end_x  = addr_x + len_x;

	assign rd_ok = (cmd.length != '0) && (len_x <= XW'(MAX_READ_RUN)) && (end_x <= cap_x);
	assign er_ok = addr_x < cap_x;
	assign pr_ok = (cmd.length != '0) && (len_x <= XW'(PAGE_BYTES)) && (end_x <= cap_x)
		&& wel_q && (po_q < cmd.length);
	assign pr_fin  = (po_q + LEN_W'(1)) == cmd.length;
	assign pr_addr = addr_x + XW'(po_q);

	assign pg_base    = {addr_x[XW-1:PW], PW'(0)};
	assign pg_end_raw = pg_base + XW'(PAGE_BYTES);
	assign pg_end     = (pg_end_raw > cap_x) ? cap_x : pg_end_raw;

	assign out_free  = !out_v_q || rsp.ready;
	assign cmd.ready = (st_q == ST_IDLE) && out_free;
	assign acc       = cmd.valid && cmd.ready;

	// read run: the RAM output holds a byte until the output register takes it
	assign move    = (st_q == ST_READ) && pend_q && out_free;
	assign issue   = (st_q == ST_READ) && (iss_q != rd_len_q) && (!pend_q || move);
	assign rd_last = (mv_q + RW'(1)) == rd_len_q;

	assign mem_re    = issue;
	assign mem_raddr = rd_ptr_q;

	always_comb begin
		st_d      = st_q;
		wel_d     = wel_q;
		po_d      = po_q;
		clr_d     = clr_q;
		ea_d      = ea_q;
		ee_d      = ee_q;
		rd_ptr_d  = rd_ptr_q;
		rd_len_d  = rd_len_q;
		iss_d     = iss_q;
		mv_d      = mv_q;
		pend_d    = pend_q;
		ld        = 1'b0;
		ld_ok     = 1'b0;
		ld_val    = '0;
		ld_last   = 1'b1;
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = CLEARED_BYTE;

		unique case (st_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				clr_d  = clr_q + AW'(1);
				if (clr_q == AW'(MEM_BYTES - 1)) begin
					st_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (acc) begin
					if (cmd.mode != MODE_PROG) begin
						po_d = '0;
					end
					unique case (cmd.mode)
						MODE_READ: begin
							if (rd_ok) begin
								st_d     = ST_READ;
								rd_ptr_d = addr_x[AW-1:0];
								rd_len_d = cmd.length[RW-1:0];
								iss_d    = '0;
								mv_d     = '0;
								pend_d   = 1'b0;
							end else begin
								ld = 1'b1;
							end
						end
						MODE_WREN: begin
							wel_d = 1'b1;
							ld    = 1'b1;
							ld_ok = 1'b1;
						end
						MODE_ERASE: begin
							ld    = 1'b1;
							ld_ok = er_ok;
							if (er_ok) begin
								wel_d = 1'b0;
								ea_d  = pg_base;
								ee_d  = pg_end;
								st_d  = ST_ERASE;
							end
						end
						MODE_PROG: begin
							ld = 1'b1;
							if (pr_ok) begin
								mem_we    = 1'b1;
								mem_waddr = pr_addr[AW-1:0];
								mem_wdata = cmd.data_byte;
								ld_ok     = 1'b1;
								ld_last   = pr_fin;
								if (pr_fin) begin
									wel_d = 1'b0;
									po_d  = '0;
								end else begin
									po_d = po_q + LEN_W'(1);
								end
							end else begin
								po_d = '0;
							end
						end
						MODE_STATUS: begin
							ld     = 1'b1;
							ld_ok  = 1'b1;
							ld_val = wel_q ? STATUS_WEL_MASK : '0;
						end
						MODE_ID: begin
							ld     = 1'b1;
							ld_ok  = 1'b1;
							ld_val = cfg.device_id;
						end
						default: begin
							ld = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				if (move) begin
					ld      = 1'b1;
					ld_ok   = 1'b1;
					ld_val  = VALUE_W'(mem_rdata);
					ld_last = rd_last;
					mv_d    = mv_q + RW'(1);
					if (rd_last) begin
						st_d = ST_IDLE;
					end
				end
				if (issue) begin
					iss_d    = iss_q + RW'(1);
					rd_ptr_d = rd_ptr_q + AW'(1);
					pend_d   = 1'b1;
				end else if (move) begin
					pend_d = 1'b0;
				end
			end
			ST_ERASE: begin
				mem_we    = 1'b1;
				mem_waddr = ea_q[AW-1:0];
				mem_wdata = ERASED_BYTE;
				ea_d      = ea_q + XW'(1);
				if (ea_q + XW'(1) == ee_q) begin
					st_d = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_CLEAR;
			wel_q    <= 1'b0;
			po_q     <= '0;
			clr_q    <= '0;
			ea_q     <= '0;
			ee_q     <= '0;
			rd_ptr_q <= '0;
			rd_len_q <= '0;
			iss_q    <= '0;
			mv_q     <= '0;
			pend_q   <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			st_q     <= st_d;
			wel_q    <= wel_d;
			po_q     <= po_d;
			clr_q    <= clr_d;
			ea_q     <= ea_d;
			ee_q     <= ee_d;
			rd_ptr_q <= rd_ptr_d;
			rd_len_q <= rd_len_d;
			iss_q    <= iss_d;
			mv_q     <= mv_d;
			pend_q   <= pend_d;
			if (ld) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			rsp_ok_q   <= ld_ok;
			rsp_val_q  <= ld_val;
			rsp_last_q <= ld_last;
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.ok    = rsp_ok_q;
	assign rsp.value = rsp_val_q;
	assign rsp.last  = rsp_last_q;
endmodule

[hw/rtl/spi_nor_flash_model.sv]
// Top level of the serial NOR flash: config registers, command sequencer and byte store.
//
//  channel  dir  handshake            payload
//  cmd      in   valid/ready          mode, address, length, data_byte
//  rsp      out  valid/ready          ok, value, last
//  apb      in   psel/penable/pready  paddr, pwdata, pwrite -> prdata
//
// After reset a clearing pass zeroes the store, one byte per cycle, with cmd.ready
// low; config writes are taken during it.
// For single-result commands (write enable, status, ID, program byte, refusals) the
// result sits in the output register the cycle after acceptance.
// A read run streams one byte per cycle off the RAM read port while rsp is not
// stalled; an erase walks the page on the RAM write port, one byte per cycle, and
// cmd.ready stays low while either runs.
// A stalled rsp holds its item and backpressures reads; a new command is taken as
// soon as the output register is empty or being drained.
`timescale 1ns / 1ps
module spi_nor_flash_model #(
	parameter int MEM_BYTES    = snf_pkg::MEM_BYTES_DEF,
	parameter int PAGE_BYTES   = snf_pkg::PAGE_BYTES_DEF,
	parameter int MAX_READ_RUN = snf_pkg::MAX_READ_RUN_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	snf_cmd_if.sink                     cmd,
	snf_rsp_if.source                   rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [snf_pkg::PADDR_W-1:0] paddr,
	input  logic [snf_pkg::PDATA_W-1:0] pwdata,
	output logic [snf_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import snf_pkg::*;

	localparam int AW = $clog2(MEM_BYTES);

	cfg_t              cfg;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [DATA_W-1:0] mem_rdata;

	// device ID and capacity; capacity is clamped to MEM_BYTES inside the sequencer
	snf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// holds the latch and program offset, drives both RAM ports
	snf_ctrl #(
		.MEM_BYTES    (MEM_BYTES),
		.PAGE_BYTES   (PAGE_BYTES),
		.MAX_READ_RUN (MAX_READ_RUN)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.rsp       (rsp),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// byte store
	snf_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MEM_BYTES)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);
endmodule

[hw/rtl/snf_checker.sv]
// Checker on the top-level ports of the serial NOR flash, with its bind.
`timescale 1ns / 1ps
module snf_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cmd_valid,
	input logic                         cmd_ready,
	input logic [snf_pkg::MODE_W-1:0]   cmd_mode,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic                         rsp_ok,
	input logic [snf_pkg::VALUE_W-1:0]  rsp_value,
	input logic                         rsp_last
);
	import snf_pkg::*;

	// out of reset the store is being cleared: nothing in flight, no command taken
	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !rsp_valid && !cmd_ready)
		else $error("item or ready right after reset");

	a_refuse_form: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ok |-> rsp_last && rsp_value == '0)
		else $error("refused item not single and zero");

	a_wren_resp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_mode == MODE_WREN
		|=> rsp_valid && rsp_ok && rsp_last && rsp_value == '0)
		else $error("write enable item not answered next cycle");

	a_bad_mode: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_mode > MODE_ID |=> rsp_valid && !rsp_ok)
		else $error("unknown mode not refused");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready
		|=> rsp_valid && $stable(rsp_ok) && $stable(rsp_value) && $stable(rsp_last))
		else $error("stalled item changed");
endmodule

bind spi_nor_flash_model snf_checker u_snf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.cmd_mode  (cmd.mode),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_ok    (rsp.ok),
	.rsp_value (rsp.value),
	.rsp_last  (rsp.last)
);

[bench/spi_nor_flash_model_tb.sv]
// Self-checking bench for the serial NOR flash: command stream, result check, register setup.
`timescale 1ns / 1ps
module spi_nor_flash_model_tb;
	import snf_pkg::*;

	// The block only knows modes 0..5; the two spare codes must come back refused.
	localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

	// An erase walks at most one page, one byte per cycle; give it some margin.
	localparam int SETTLE_CYCLES = 300;
	// Receiver hold-off, long enough to fill the output path and stall cmd.
	localparam int HOLD_CYCLES   = 600;
	// Random traffic is aimed at a window so reads find programmed bytes.
	localparam int HOT_SPAN      = 768;
	localparam int PHASE_ITEMS   = 94;

	typedef struct {
		logic [MODE_W-1:0] mode;
		logic [ADDR_W-1:0] address;
		logic [LEN_W-1:0]  length;
		logic [DATA_W-1:0] data_byte;
	} flash_cmd_t;

	typedef struct {
		logic               ok;
		logic [VALUE_W-1:0] value;
		logic               last;
	} flash_rsp_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	snf_cmd_if cmd_ch ();
	snf_rsp_if rsp_ch ();

	spi_nor_flash_model i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow of the flash: byte image, write-enable latch, program run position
	// and the two registers as last written.
	logic [DATA_W-1:0]  store_img [MEM_BYTES_DEF];
	logic               wel_img;
	int unsigned        prog_pos;
	logic [VALUE_W-1:0] id_img;
	logic [CAP_W-1:0]   cap_img;

	flash_cmd_t  cmd_backlog [$];    // items waiting for the driver
	flash_rsp_t  flash_answers [$];  // results the flash still owes, oldest first
	int          bad_count = 0;
	int unsigned items_queued = 0;
	int unsigned hot_base = 0;
	logic        steady;             // no idling on either side while set
	logic        hold_arm;           // asks the receiver for one long hold-off
	logic        hold_done;
	int          hold_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Capacity as the flash sees it: anything past the array acts as the array size.
	function automatic int unsigned cap_in_use();
		return (cap_img > MEM_BYTES_DEF) ? MEM_BYTES_DEF : int'(cap_img);
	endfunction

	function automatic void owe(input logic ok, input logic [VALUE_W-1:0] value,
		input logic last);
		flash_rsp_t r;
		r.ok    = ok;
		r.value = value;
		r.last  = last;
		flash_answers.push_back(r);
	endfunction

	// Apply one accepted command to the shadow and list the results it causes.
	function automatic void flash_predict(input flash_cmd_t c);
		int unsigned cap;
		int unsigned a;
		int unsigned n;
		int unsigned base;
		int unsigned top;
		int unsigned i;
		cap = cap_in_use();
		a   = 32'(c.address);
		n   = 32'(c.length);
		// Any other command breaks off a program run.
		if (c.mode != MODE_PROG)
			prog_pos = 0;
		case (c.mode)
			MODE_READ: begin
				if (n == 0 || n > MAX_READ_RUN_DEF || a + n > cap) begin
					owe(1'b0, '0, 1'b1);
				end else begin
					for (i = 0; i < n; i++)
						owe(1'b1, VALUE_W'(store_img[a + i]), i + 1 == n);
				end
			end
			MODE_WREN: begin
				wel_img = 1'b1;
				owe(1'b1, '0, 1'b1);
			end
			MODE_ERASE: begin
				// Out of range leaves the latch alone; otherwise the page goes to
				// the erased value, clipped at the capacity, and the latch drops.
				if (a >= cap) begin
					owe(1'b0, '0, 1'b1);
				end else begin
					base = a / PAGE_BYTES_DEF * PAGE_BYTES_DEF;
					top  = (base + PAGE_BYTES_DEF > cap) ? cap : base + PAGE_BYTES_DEF;
					for (i = base; i < top; i++)
						store_img[i] = ERASED_BYTE;
					wel_img = 1'b0;
					owe(1'b1, '0, 1'b1);
				end
			end
			MODE_PROG: begin
				if (n == 0 || n > PAGE_BYTES_DEF || a + n > cap || !wel_img || prog_pos >= n) begin
					prog_pos = 0;
					owe(1'b0, '0, 1'b1);
				end else begin
					store_img[a + prog_pos] = c.data_byte;
					if (prog_pos + 1 == n) begin
						wel_img  = 1'b0;
						prog_pos = 0;
						owe(1'b1, '0, 1'b1);
					end else begin
						prog_pos++;
						owe(1'b1, '0, 1'b0);
					end
				end
			end
			MODE_STATUS: owe(1'b1, wel_img ? STATUS_WEL_MASK : '0, 1'b1);
			MODE_ID:     owe(1'b1, id_img, 1'b1);
			default:     owe(1'b0, '0, 1'b1);
		endcase
	endfunction

	function automatic void queue_cmd(input logic [MODE_W-1:0] mode, input int unsigned address,
		input int unsigned length, input int unsigned data_byte);
		flash_cmd_t c;
		c.mode      = mode;
		c.address   = address[ADDR_W-1:0];
		c.length    = length[LEN_W-1:0];
		c.data_byte = data_byte[DATA_W-1:0];
		cmd_backlog.push_back(c);
		items_queued++;
	endfunction

	// Start address for a run of n bytes inside the hot window. If the window
	// is too short the run hangs off the end and comes back refused.
	function automatic int unsigned pick_addr(input int unsigned n);
		int unsigned cap;
		int unsigned span;
		cap  = cap_in_use();
		span = (cap > hot_base) ? cap - hot_base : 0;
		if (span > HOT_SPAN)
			span = HOT_SPAN;
		if (span < n)
			return hot_base;
		return hot_base + $urandom_range(span - n);
	endfunction

	function automatic void aim_hot_spot();
		hot_base = (cap_in_use() > HOT_SPAN) ? $urandom_range(cap_in_use() - HOT_SPAN) : 0;
	endfunction

	// Mostly well-formed traffic: full program runs behind a write enable and
	// reads over the same window. The rest is broken runs and raw noise.
	task automatic queue_random(input int unsigned count);
		int unsigned stop;
		int unsigned roll;
		int unsigned n;
		int unsigned a;
		int unsigned k;
		int unsigned cut;
		stop = items_queued + count;
		while (items_queued < stop) begin
			roll = $urandom_range(99);
			if (roll < 32) begin
				n = ($urandom_range(19) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
				a = pick_addr(n);
				if ($urandom_range(19) != 0)
					queue_cmd(MODE_WREN, $urandom_range(65535), $urandom_range(511),
						$urandom_range(255));
				// Now and then the run is dropped before its final byte.
				cut = ($urandom_range(6) == 0) ? $urandom_range(n - 1) : n;
				for (k = 0; k < cut; k++)
					queue_cmd(MODE_PROG, a, n, $urandom_range(255));
				// Length shrunk below the bytes already taken.
				if (cut != 0 && cut < n && $urandom_range(2) == 0)
					queue_cmd(MODE_PROG, a, cut, $urandom_range(255));
			end else if (roll < 57) begin
				n = $urandom_range(1, MAX_READ_RUN_DEF);
				queue_cmd(MODE_READ, pick_addr(n), n, $urandom_range(255));
			end else if (roll < 65) begin
				a = ($urandom_range(4) == 0) ? $urandom_range(65535) : pick_addr(1);
				queue_cmd(MODE_ERASE, a, $urandom_range(511), $urandom_range(255));
			end else if (roll < 75) begin
				case ($urandom_range(2))
					0:       queue_cmd(MODE_STATUS, $urandom_range(65535), $urandom_range(511),
						$urandom_range(255));
					1:       queue_cmd(MODE_ID, $urandom_range(65535), $urandom_range(511),
						$urandom_range(255));
					default: queue_cmd(MODE_WREN, $urandom_range(65535), $urandom_range(511),
						$urandom_range(255));
				endcase
			end else begin
				queue_cmd(MODE_W'($urandom_range(7)), $urandom_range(65535), $urandom_range(511),
					$urandom_range(255));
			end
		end
	endtask

	// APB write: setup cycle, then access; pready is polled, though always high.
	task automatic reg_write(input logic idx, input logic [PDATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_DEVICE_ID)
			id_img = data;
		else
			cap_img = data[CAP_W-1:0];
	endtask

	// Wait until every item is taken and every result has come, then give a
	// possible erase walk time to finish before anything else changes.
	task automatic drain();
		do @(posedge clk);
		while (cmd_backlog.size() != 0 || cmd_ch.valid || flash_answers.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Command driver: offers the next item whenever the slot is free, with
	// about 6% idle cycles outside the steady stretch.
	always @(posedge clk or negedge arst_n) begin : cmd_driver
		flash_cmd_t c;
		if (!arst_n) begin
			cmd_ch.valid     <= 1'b0;
			cmd_ch.mode      <= MODE_READ;
			cmd_ch.address   <= '0;
			cmd_ch.length    <= '0;
			cmd_ch.data_byte <= '0;
		end else if (!cmd_ch.valid || cmd_ch.ready) begin
			if (cmd_backlog.size() != 0 && (steady || $urandom_range(99) >= 6)) begin
				c = cmd_backlog.pop_front();
				cmd_ch.valid     <= 1'b1;
				cmd_ch.mode      <= c.mode;
				cmd_ch.address   <= c.address;
				cmd_ch.length    <= c.length;
				cmd_ch.data_byte <= c.data_byte;
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls, plus one long hold-off counted here.
	always @(posedge clk or negedge arst_n) begin : rsp_receiver
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_left    <= 0;
			hold_done    <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			rsp_ch.ready <= (hold_left == 1);
		end else if (hold_arm && !hold_done) begin
			hold_done    <= 1'b1;
			hold_left    <= HOLD_CYCLES;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= steady || $urandom_range(99) >= 6;
		end
	end

	// Monitor: check each result against the oldest owed one, then feed each
	// accepted command to the shadow.
	always @(posedge clk) begin : flash_monitor
		flash_rsp_t want;
		flash_cmd_t c;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (flash_answers.size() == 0) begin
				bad_count = bad_count + 1;
				if (bad_count <= 10)
					$display("%0t: result with none owed: ok %0b value %h last %0b",
						$time, rsp_ch.ok, rsp_ch.value, rsp_ch.last);
			end else begin
				want = flash_answers.pop_front();
				if (rsp_ch.ok !== want.ok || rsp_ch.value !== want.value ||
					rsp_ch.last !== want.last) begin
					bad_count = bad_count + 1;
					if (bad_count <= 10)
						$display("%0t: wrong result: ok %0b/%0b value %h/%h last %0b/%0b (exp/got)",
							$time, want.ok, rsp_ch.ok, want.value, rsp_ch.value,
							want.last, rsp_ch.last);
				end
			end
		end
		if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
			c.mode      = cmd_ch.mode;
			c.address   = cmd_ch.address;
			c.length    = cmd_ch.length;
			c.data_byte = cmd_ch.data_byte;
			flash_predict(c);
		end
	end

	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		steady   = 1'b0;
		hold_arm = 1'b0;
		foreach (store_img[k])
			store_img[k] = CLEARED_BYTE;
		wel_img  = 1'b0;
		prog_pos = 0;
		id_img   = '0;
		cap_img  = CAP_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Full array, all-ones ID. The store starts out cleared.
		reg_write(REG_DEVICE_ID, 32'hFFFF_FFFF);
		reg_write(REG_CAPACITY, MEM_BYTES_DEF);
		queue_cmd(MODE_READ, 'hFFFF, 1, 'hFF);                      // very last byte
		queue_cmd(MODE_READ, 'hFFC0, MAX_READ_RUN_DEF, 0);          // longest run, to the end
		queue_cmd(MODE_READ, 'h0100, 0, 0);                         // zero length
		queue_cmd(MODE_READ, 'h0100, MAX_READ_RUN_DEF + 1, 0);      // run too long
		queue_cmd(MODE_READ, 'hFFFF, 2, 0);                         // runs past the capacity
		queue_cmd(MODE_ID, 0, 0, 0);
		queue_cmd(MODE_SPARE_6, 0, 0, 0);
		queue_cmd(MODE_SPARE_7, 'hFFFF, 'h1FF, 'hFF);
		queue_cmd(MODE_PROG, 'h1280, 1, 'h5A);                      // latch still clear
		queue_cmd(MODE_WREN, 0, 0, 0);
		queue_cmd(MODE_PROG, 'h1280, 0, 0);                         // zero length
		queue_cmd(MODE_PROG, 'h1280, PAGE_BYTES_DEF + 1, 0);        // longer than a page
		queue_cmd(MODE_PROG, 'hFFFF, 2, 0);                         // past the capacity
		queue_cmd(MODE_PROG, 'h1280, 3, 'h00);                      // complete run, latch drops
		queue_cmd(MODE_PROG, 'h1280, 3, 'hFF);
		queue_cmd(MODE_PROG, 'h1280, 3, 'hA5);
		queue_cmd(MODE_READ, 'h1280, 3, 0);
		queue_cmd(MODE_WREN, 0, 0, 0);
		queue_cmd(MODE_PROG, 'h2000, PAGE_BYTES_DEF, 'hC3);         // full-page run, two bytes in
		queue_cmd(MODE_PROG, 'h2000, PAGE_BYTES_DEF, 'h3C);
		queue_cmd(MODE_PROG, 'h2000, 1, 'h77);                      // length under bytes taken
		queue_cmd(MODE_STATUS, 0, 0, 0);                            // latch survives refusals
		queue_cmd(MODE_ERASE, 'h12FF, 0, 0);
		queue_cmd(MODE_STATUS, 0, 0, 0);
		queue_cmd(MODE_ERASE, 'hFFFF, 0, 0);                        // top page
		queue_cmd(MODE_READ, 'hFFC0, MAX_READ_RUN_DEF, 0);

		// One byte of capacity: the erase is clipped to that byte.
		drain();
		reg_write(REG_CAPACITY, 1);
		reg_write(REG_DEVICE_ID, 0);
		queue_cmd(MODE_ERASE, 1, 0, 0);
		queue_cmd(MODE_ERASE, 0, 0, 0);
		queue_cmd(MODE_READ, 0, 1, 0);
		queue_cmd(MODE_READ, 0, 2, 0);

		// Zero capacity refuses every access.
		drain();
		reg_write(REG_CAPACITY, 0);
		queue_cmd(MODE_READ, 0, 1, 0);
		queue_cmd(MODE_ERASE, 0, 0, 0);

		// Register at its top value behaves as the full array.
		drain();
		reg_write(REG_CAPACITY, 32'h0001_FFFF);
		queue_cmd(MODE_READ, 'hFFC0, MAX_READ_RUN_DEF, 0);
		queue_cmd(MODE_ERASE, 'hFFFF, 0, 0);

		// Random traffic, full array, no idling on either side.
		drain();
		reg_write(REG_DEVICE_ID, $urandom);
		reg_write(REG_CAPACITY, MEM_BYTES_DEF);
		aim_hot_spot();
		steady <= 1'b1;
		queue_random(PHASE_ITEMS);
		drain();
		steady <= 1'b0;

		// Small array; the receiver stalls for a long stretch at the start.
		reg_write(REG_CAPACITY, $urandom_range(300, 4096));
		aim_hot_spot();
		hold_arm <= 1'b1;
		queue_random(PHASE_ITEMS);

		drain();
		reg_write(REG_DEVICE_ID, 0);
		reg_write(REG_CAPACITY, $urandom_range(1, MEM_BYTES_DEF));
		aim_hot_spot();
		queue_random(PHASE_ITEMS);

		// Capacity above the array size.
		drain();
		reg_write(REG_DEVICE_ID, $urandom);
		reg_write(REG_CAPACITY, $urandom_range(MEM_BYTES_DEF + 1, 131071));
		aim_hot_spot();
		queue_random(PHASE_ITEMS);

		drain();
		if (bad_count == 0 && flash_answers.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
